// ===== hdl/wsd_pkg.sv =====
package wsd_pkg;

   // ring geometry
   localparam int DEPTH_LOG  = 10;
   localparam int SLOT_COUNT = 1 << DEPTH_LOG;
   localparam int IDX_W      = DEPTH_LOG + 1;

   // operation codes
   localparam logic [1:0] KIND_PUT   = 2'd0;
   localparam logic [1:0] KIND_TAKE  = 2'd1;
   localparam logic [1:0] KIND_STEAL = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] task_in;
   } req_word_type;

   typedef struct packed {
      logic [31:0] task_out;
      logic [1:0]  status;
   } rsp_word_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic exec;
   } dp_cmd_type;

endpackage

// ===== hdl/wsd_ctrl.sv =====
module wsd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                rsp_strobe,
   output wsd_pkg::dp_cmd_type cmd
);

   wsd_pkg::state_type state_ff;
   wsd_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wsd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      cmd.load   = 1'b0;
      cmd.exec   = 1'b0;
      case (state_ff)
         wsd_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = wsd_pkg::ST_EXEC;
            end
         end
         wsd_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = wsd_pkg::ST_DONE;
         end
         wsd_pkg::ST_DONE: begin
            rsp_strobe = 1'b1;
            state_in   = wsd_pkg::ST_IDLE;
         end
         default: begin
            state_in = wsd_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/wsd_datapath.sv =====
module wsd_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  wsd_pkg::dp_cmd_type   cmd,
   input  wsd_pkg::req_word_type req_word,
   output wsd_pkg::rsp_word_type rsp_word
);

   localparam int DL = wsd_pkg::DEPTH_LOG;
   localparam int IW = wsd_pkg::IDX_W;

   logic [31:0] slot_mem [wsd_pkg::SLOT_COUNT];

   wsd_pkg::req_word_type req_ff;
   logic [IW-1:0] top_ff, top_in;
   logic [IW-1:0] bottom_ff, bottom_in;
   logic [31:0]   rdata_ff;
   logic          read_sel_ff, read_sel_in;
   logic [1:0]    status_ff, status_in;

   logic [IW-1:0] queued;
   logic [IW-1:0] bottom_dec;
   logic          is_full;
   logic          is_empty;
   logic          wr_en;
   logic          rd_en;
   logic [DL-1:0] rd_addr;

   assign queued     = bottom_ff - top_ff;
   assign bottom_dec = bottom_ff - IW'(1);
   // count never exceeds SLOT_COUNT, so the top bit alone marks full
   assign is_full    = queued[DL];
   assign is_empty   = (queued == '0);

   always_comb begin
      top_in      = top_ff;
      bottom_in   = bottom_ff;
      status_in   = wsd_pkg::STATUS_OK;
      read_sel_in = 1'b0;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = top_ff[DL-1:0];
      case (req_ff.kind)
         wsd_pkg::KIND_PUT: begin
            if (is_full) begin
               status_in = wsd_pkg::STATUS_FULL;
            end else begin
               wr_en     = 1'b1;
               bottom_in = bottom_ff + IW'(1);
            end
         end
         wsd_pkg::KIND_TAKE: begin
            if (is_empty) begin
               status_in = wsd_pkg::STATUS_EMPTY;
            end else begin
               rd_en       = 1'b1;
               read_sel_in = 1'b1;
               rd_addr     = bottom_dec[DL-1:0];
               // last task leaves via top so both indices meet
               if (queued == IW'(1)) begin
                  top_in = top_ff + IW'(1);
               end else begin
                  bottom_in = bottom_dec;
               end
            end
         end
         wsd_pkg::KIND_STEAL: begin
            if (is_empty) begin
               status_in = wsd_pkg::STATUS_EMPTY;
            end else begin
               rd_en       = 1'b1;
               read_sel_in = 1'b1;
               top_in      = top_ff + IW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff    <= IW'(1);
         bottom_ff <= IW'(1);
      end else if (cmd.exec) begin
         top_ff    <= top_in;
         bottom_ff <= bottom_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_word;
      end
      if (cmd.exec) begin
         status_ff   <= status_in;
         read_sel_ff <= read_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         slot_mem[bottom_ff[DL-1:0]] <= req_ff.task_in;
      end
      if (cmd.exec && rd_en) begin
         rdata_ff <= slot_mem[rd_addr];
      end
   end

   assign rsp_word.task_out = read_sel_ff ? rdata_ff : 32'd0;
   assign rsp_word.status   = status_ff;

endmodule

// ===== hdl/work_stealing_deque.sv =====
// Fixed-capacity work-stealing deque (Chase-Lev style) for 32-bit task
// handles, 2^DEPTH_LOG slots held in a single-port ring memory. Each word
// is a put (store at bottom), a take (newest task, from bottom) or a steal
// (oldest task, from top); every operation is atomic. A word is accepted
// when start is high and busy is low, and exactly one result word appears
// on rsp_word for one cycle with rsp_strobe high, after the execute state.
// The receiver cannot stall: capture the result on the strobe. busy stays
// high in the execute and result states, so no new word is taken before
// the last result is out; this is set by the registered read port of the
// slot memory (execute cycle addresses it, result cycle presents the data).
// Status: ok, empty (take/steal on an empty deque, task_out zero) or full
// (put dropped). Unused kind 3 returns ok with task_out zero. The slot
// memory is not cleared at reset; only occupied slots are ever read.

module work_stealing_deque (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  wsd_pkg::req_word_type req_word,
   output logic                  rsp_strobe,
   output wsd_pkg::rsp_word_type rsp_word
);

   wsd_pkg::dp_cmd_type cmd;

   // sequencing: idle -> execute -> result
   wsd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   // indices, slot memory and result registers
   wsd_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_word (req_word),
      .rsp_word (rsp_word)
   );

`ifndef SYNTHESIS
   // an accepted word yields its result strobe after the execute state
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> ##1 rsp_strobe)
      else $error("result strobe missing two cycles after accept");

   // no new word is taken while a result is going out
   a_busy_on_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("block idle while result strobe is high");

   // strobe is a single-cycle pulse
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held longer than one cycle");

   // empty and full results never carry a task
   a_no_task_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_word.status != wsd_pkg::STATUS_OK) |->
         rsp_word.task_out == 32'd0)
      else $error("task returned with a failure status");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

   // kind 3 has no name in the package; the block must treat it as a no-op
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // stimulus sizing
   localparam int RANDOM_WORDS = 1450;
   localparam int DRAIN_LIMIT  = 200;   // cycles allowed for owed results
   localparam int TAIL_CYCLES  = 8;     // quiet cycles after the last result

   // -------------------------------------------------------------------
   // Scoreboard: keeps a mirror of the deque (ring store, top and bottom
   // indexes) and the queue of result words owed by the block.
   // -------------------------------------------------------------------
   class deque_scoreboard;
      logic [31:0]               slot_mem [wsd_pkg::SLOT_COUNT];
      logic [wsd_pkg::IDX_W-1:0] top_idx;
      logic [wsd_pkg::IDX_W-1:0] bot_idx;
      wsd_pkg::rsp_word_type     owed_q [$];
      int                        mismatch_count;

      function new();
         top_idx        = wsd_pkg::IDX_W'(1);
         bot_idx        = wsd_pkg::IDX_W'(1);
         mismatch_count = 0;
      endfunction

      // number of queued tasks, 0 .. SLOT_COUNT
      function int occupancy();
         logic [wsd_pkg::IDX_W-1:0] fill;
         fill = bot_idx - top_idx;
         return int'(fill);
      endfunction

      // apply one accepted request word to the mirror, queue its result
      function void note_word(wsd_pkg::req_word_type w);
         logic [wsd_pkg::IDX_W-1:0] fill;
         logic [wsd_pkg::IDX_W-1:0] last_idx;
         wsd_pkg::rsp_word_type     r;
         fill       = bot_idx - top_idx;
         last_idx   = bot_idx - wsd_pkg::IDX_W'(1);
         r.task_out = '0;
         r.status   = wsd_pkg::STATUS_OK;
         case (w.kind)
            wsd_pkg::KIND_PUT: begin
               if (fill >= wsd_pkg::SLOT_COUNT) begin
                  r.status = wsd_pkg::STATUS_FULL;   // dropped, nothing moves
               end else begin
                  slot_mem[bot_idx[wsd_pkg::DEPTH_LOG-1:0]] = w.task_in;
                  bot_idx = bot_idx + wsd_pkg::IDX_W'(1);
               end
            end
            wsd_pkg::KIND_TAKE: begin
               if (fill == 0) begin
                  r.status = wsd_pkg::STATUS_EMPTY;
               end else begin
                  r.task_out = slot_mem[last_idx[wsd_pkg::DEPTH_LOG-1:0]];
                  // last task: top catches up, bottom stays put
                  if (fill == 1) top_idx = top_idx + wsd_pkg::IDX_W'(1);
                  else           bot_idx = last_idx;
               end
            end
            wsd_pkg::KIND_STEAL: begin
               if (fill == 0) begin
                  r.status = wsd_pkg::STATUS_EMPTY;
               end else begin
                  r.task_out = slot_mem[top_idx[wsd_pkg::DEPTH_LOG-1:0]];
                  top_idx    = top_idx + wsd_pkg::IDX_W'(1);
               end
            end
            default: ;                      // unused kind: ok, zero
         endcase
         owed_q.push_back(r);
      endfunction

      // compare one result word with the oldest owed one
      function void check_word(wsd_pkg::rsp_word_type got);
         wsd_pkg::rsp_word_type want;
         if (owed_q.size() == 0) begin
            $display("%0t: unexpected result word, expected none, got %h/%0d",
                     $time, got.task_out, got.status);
            mismatch_count++;
         end else begin
            want = owed_q.pop_front();
            if (got.task_out !== want.task_out) begin
               $display("%0t: task_out mismatch, expected %h, got %h",
                        $time, want.task_out, got.task_out);
               mismatch_count++;
            end
            if (got.status !== want.status) begin
               $display("%0t: status mismatch, expected %0d, got %0d",
                        $time, want.status, got.status);
               mismatch_count++;
            end
         end
      endfunction
   endclass

   // -------------------------------------------------------------------
   // DUT hookup
   // -------------------------------------------------------------------
   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   wsd_pkg::req_word_type req_word;
   logic                  rsp_strobe;
   wsd_pkg::rsp_word_type rsp_word;

   deque_scoreboard sb = new();

   int random_count = 0;   // random words sent, unused kind not counted
   bit no_idle      = 1'b0; // when set, words go back to back

   work_stealing_deque dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   // 2 ns clock
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Result side: the block cannot be held off, so every strobe is a
   // word that must match right now. Sampled at the edge, i.e. the value
   // the block presented during the cycle that just ended.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_word(rsp_word);
   end

   // Present one word, idle first for a random gap, then wait for the
   // handshake (start high, busy low at the edge). When the gap is zero,
   // start simply stays high from the previous word.
   task automatic send_word(input wsd_pkg::req_word_type w);
      int gap;
      if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
      if (no_idle)                         gap = 0;
      else if ($urandom_range(0, 15) == 0) gap = $urandom_range(4, 30);
      else                                 gap = $urandom_range(0, 2);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_word(w);
   endtask

   // One random word; put_pct sets the share of puts, which steers the
   // fill level. A small share of unused-kind noise rides along.
   task automatic send_random(input int put_pct);
      wsd_pkg::req_word_type w;
      int                    r;
      r         = $urandom_range(0, 99);
      w.task_in = $urandom;
      if (r < 3)                          w.kind = KIND_UNUSED;
      else if (r < put_pct)               w.kind = wsd_pkg::KIND_PUT;
      else if ($urandom_range(0, 1) == 1) w.kind = wsd_pkg::KIND_TAKE;
      else                                w.kind = wsd_pkg::KIND_STEAL;
      if (w.kind != KIND_UNUSED) random_count++;
      send_word(w);
   endtask

   // -------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------
   initial begin
      int waited;
      reset    = 1'b1;
      start    = 1'b0;
      req_word = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty ops, unused kind, extreme handles, LIFO vs FIFO,
      // take and steal of the last task
      send_word('{wsd_pkg::KIND_TAKE,  32'h0000_0000});   // take on empty
      send_word('{wsd_pkg::KIND_STEAL, 32'hFFFF_FFFF});   // steal on empty
      send_word('{KIND_UNUSED,         32'h1234_5678});
      send_word('{wsd_pkg::KIND_PUT,   32'h0000_0000});
      send_word('{wsd_pkg::KIND_PUT,   32'hFFFF_FFFF});
      send_word('{wsd_pkg::KIND_PUT,   32'h5A5A_5A5A});
      send_word('{KIND_UNUSED,         32'hFFFF_FFFF});   // no-op on a busy deque
      send_word('{wsd_pkg::KIND_TAKE,  32'h0000_0000});   // newest: 5a5a5a5a
      send_word('{wsd_pkg::KIND_STEAL, 32'h0000_0000});   // oldest: 0
      send_word('{wsd_pkg::KIND_TAKE,  32'hFFFF_FFFF});   // last task via take
      send_word('{wsd_pkg::KIND_TAKE,  32'h0000_0000});
      send_word('{wsd_pkg::KIND_STEAL, 32'h0000_0000});
      send_word('{wsd_pkg::KIND_PUT,   32'h0000_0001});
      send_word('{wsd_pkg::KIND_PUT,   32'h8000_0000});
      send_word('{wsd_pkg::KIND_STEAL, 32'h0000_0000});
      send_word('{wsd_pkg::KIND_STEAL, 32'h0000_0000});   // last task via steal
      send_word('{wsd_pkg::KIND_PUT,   32'h7FFF_FFFF});
      send_word('{wsd_pkg::KIND_TAKE,  32'h0000_0000});   // last task via take
      send_word('{wsd_pkg::KIND_PUT,   32'hC3C3_C3C3});
      send_word('{wsd_pkg::KIND_STEAL, 32'h0000_0000});
      send_word('{wsd_pkg::KIND_STEAL, 32'h0000_0000});   // empty again

      // random: mixed traffic near empty, then fill to capacity, bounce
      // against full (dropped puts), then mostly drain
      repeat (120) send_random(45);
      while (sb.occupancy() < wsd_pkg::SLOT_COUNT) send_random(95);
      repeat (40) send_random(60);
      while (random_count < RANDOM_WORDS) send_random(25);
      start <= 1'b0;

      // let owed results come home, then a few quiet cycles
      waited = 0;
      while (sb.owed_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.owed_q.size() != 0) begin
         $display("%0t: %0d result words never arrived, expected %h/%0d, got none",
                  $time, sb.owed_q.size(), sb.owed_q[0].task_out,
                  sb.owed_q[0].status);
         sb.mismatch_count++;
      end

      if (sb.mismatch_count == 0) begin
         $display("work_stealing_deque verification clean");
      end else begin
         $display("work_stealing_deque verification failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #1000000;
      $display("work_stealing_deque verification failed");
      $finish;
   end

endmodule
